// File: rtl/frame_geometric_remap_unit_defines.svh
// ----------------------------------------------------------------------------
// frame_geometric_remap_unit_defines
// Assertion macros shared by the remap unit RTL.
// ----------------------------------------------------------------------------
`ifndef FRAME_GEOMETRIC_REMAP_UNIT_DEFINES_SVH
`define FRAME_GEOMETRIC_REMAP_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FGR_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("fgr same-cycle check failed");

// next-cycle implication, disabled during reset
`define FGR_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("fgr next-cycle check failed");

`endif

// File: rtl/fgr_pkg.sv
// ----------------------------------------------------------------------------
// fgr_pkg
// Shared types and constants of the frame geometric remap unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fgr_pkg;

  localparam int SIDE      = 256;
  localparam int COORD_W   = 8;
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int DEPTH     = SIDE * SIDE;
  localparam int PIX_W     = 24;
  localparam int MODE_W    = 4;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // register index (byte address / 4)
  localparam logic REG_REMAP_MODE = 1'b0;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDENT     = 4'd0,
    MODE_FLIP_H    = 4'd1,
    MODE_FLIP_V    = 4'd2,
    MODE_ROT90     = 4'd3,
    MODE_ROT180    = 4'd4,
    MODE_ROT270    = 4'd5,
    MODE_MIR_UP    = 4'd6,
    MODE_MIR_DOWN  = 4'd7,
    MODE_MIR_LEFT  = 4'd8,
    MODE_MIR_RIGHT = 4'd9,
    MODE_ZOOM_TL   = 4'd10,
    MODE_ZOOM_TR   = 4'd11,
    MODE_ZOOM_BL   = 4'd12,
    MODE_ZOOM_BR   = 4'd13
  } remap_mode_t;

  // one classified request waiting for the store
  typedef struct packed {
    logic               is_read;
    logic [ADDR_W-1:0]  addr;
    logic [PIX_W-1:0]   pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } req_entry_t;

endpackage

`default_nettype wire

// File: rtl/fgr_ram.sv
// ----------------------------------------------------------------------------
// fgr_ram
// Single-port RAM, registered read, write has priority over read.
// ----------------------------------------------------------------------------
`default_nettype none

module fgr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/fgr_front.sv
// ----------------------------------------------------------------------------
// fgr_front
// Accepts items, maps read positions to a store address, pushes to queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fgr_front (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          req_type,
  input  wire logic [fgr_pkg::COORD_W-1:0]   row,
  input  wire logic [fgr_pkg::COORD_W-1:0]   col,
  input  wire logic [7:0]                    red_in,
  input  wire logic [7:0]                    green_in,
  input  wire logic [7:0]                    blue_in,
  input  wire logic [fgr_pkg::MODE_W-1:0]    remap_mode,
  input  wire logic                          q_full,
  output logic                               push,
  output fgr_pkg::req_entry_t                entry
);

  import fgr_pkg::*;

  logic [COORD_W-1:0] src_row;
  logic [COORD_W-1:0] src_col;

  // SIDE-1-x is the bitwise complement on a full-width coordinate;
  // half-frame test is the coordinate msb.
  always_comb begin
    src_row = row;
    src_col = col;
    case (remap_mode_t'(remap_mode))
      MODE_FLIP_H:    src_col = ~col;
      MODE_FLIP_V:    src_row = ~row;
      MODE_ROT90: begin
        src_row = ~col;
        src_col = row;
      end
      MODE_ROT180: begin
        src_row = ~row;
        src_col = ~col;
      end
      MODE_ROT270: begin
        src_row = col;
        src_col = ~row;
      end
      MODE_MIR_UP:    if (row[COORD_W-1])  src_row = ~row;
      MODE_MIR_DOWN:  if (!row[COORD_W-1]) src_row = ~row;
      MODE_MIR_LEFT:  if (col[COORD_W-1])  src_col = ~col;
      MODE_MIR_RIGHT: if (!col[COORD_W-1]) src_col = ~col;
      MODE_ZOOM_TL: begin
        src_row = {1'b0, row[COORD_W-1:1]};
        src_col = {1'b0, col[COORD_W-1:1]};
      end
      MODE_ZOOM_TR: begin
        src_row = {1'b0, row[COORD_W-1:1]};
        src_col = {1'b1, col[COORD_W-1:1]};
      end
      MODE_ZOOM_BL: begin
        src_row = {1'b1, row[COORD_W-1:1]};
        src_col = {1'b0, col[COORD_W-1:1]};
      end
      MODE_ZOOM_BR: begin
        src_row = {1'b1, row[COORD_W-1:1]};
        src_col = {1'b1, col[COORD_W-1:1]};
      end
      default: begin
        src_row = row;
        src_col = col;
      end
    endcase
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    entry.is_read = (req_type == REQ_READ);
    entry.addr    = entry.is_read ? {src_row, src_col} : {row, col};
    entry.pix     = {red_in, green_in, blue_in};
    entry.row     = row;
    entry.col     = col;
  end

endmodule

`default_nettype wire

// File: rtl/fgr_queue.sv
// ----------------------------------------------------------------------------
// fgr_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_geometric_remap_unit_defines.svh"

module fgr_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire fgr_pkg::req_entry_t  push_entry,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      head_valid,
  output fgr_pkg::req_entry_t       head
);

  import fgr_pkg::*;

  req_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign full       = (count == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `FGR_ASSERT_IMP(a_q_no_overflow, clk, rst, push, !full)
  `FGR_ASSERT_IMP(a_q_no_underflow, clk, rst, pop, head_valid)
  `FGR_ASSERT_IMP(a_q_count_bound, clk, rst, 1'b1, count <= (QPTR_W+1)'(QDEPTH))

endmodule

`default_nettype wire

// File: rtl/fgr_back.sv
// ----------------------------------------------------------------------------
// fgr_back
// Executes queued requests on the frame store and drives the result port.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_geometric_remap_unit_defines.svh"

module fgr_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         head_valid,
  input  wire fgr_pkg::req_entry_t          head,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        red_out,
  output logic [7:0]                        green_out,
  output logic [7:0]                        blue_out,
  output logic [fgr_pkg::COORD_W-1:0]       out_row,
  output logic [fgr_pkg::COORD_W-1:0]       out_col
);

  import fgr_pkg::*;

  logic [PIX_W-1:0]   rd_data;
  logic               s1_valid;   // read issued, data on rd_data
  logic [COORD_W-1:0] s1_row;
  logic [COORD_W-1:0] s1_col;
  logic               out_free;
  logic               s1_move;

  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_free;
  // rd_data only changes on a read, so hold the queue while s1 is stuck
  assign pop      = head_valid && (!s1_valid || out_free);

  fgr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (pop),
    .we    (!head.is_read),
    .addr  (head.addr),
    .wdata (head.pix),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && head.is_read) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.is_read) begin
      s1_row <= head.row;
      s1_col <= head.col;
    end
    if (s1_move) begin
      red_out   <= rd_data[23:16];
      green_out <= rd_data[15:8];
      blue_out  <= rd_data[7:0];
      out_row   <= s1_row;
      out_col   <= s1_col;
    end
  end

  `FGR_ASSERT_NXT(a_s1_hold, clk, rst, s1_valid && !out_free, s1_valid && $stable(rd_data))
  `FGR_ASSERT_NXT(a_write_no_result, clk, rst, pop && !head.is_read, !s1_valid)
  `FGR_ASSERT_IMP(a_pop_when_free, clk, rst, pop, !s1_valid || out_free)

endmodule

`default_nettype wire

// File: rtl/frame_geometric_remap_unit.sv
// ----------------------------------------------------------------------------
// frame_geometric_remap_unit
// 256x256 RGB frame store with a geometric remap applied on readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): req_type 0 writes {red,green,blue}_in
//   at (row, col); req_type 1 asks for the pixel shown at output position
//   (row, col) under remap_mode. Writes give no result; each read gives one
//   item on the output channel (out_valid/out_ready) with the source pixel and
//   the requested row/col echoed back.
//   Config: APB register 0 (byte address 0) is remap_mode, 4 bits, reset 0.
//   Modes 14 and 15 act as identity. Write it only while the unit is idle.
//   Throughput: one item per cycle sustained while out_ready is high; every
//   item costs one access on the single store port, which sets that rate.
//   Read path: an accepted read waits in the queue, is read from the store,
//   then its result is registered in the output register and shown there.
//   Reset: control state clears, remap_mode returns to identity; store
//   contents are not cleared, reading an unwritten pixel is undefined.
//   Stall: when out_ready is low the output register holds, one more read
//   waits in the store read stage, and the 4-entry queue fills before
//   in_ready drops. Writes queued behind that waiting read wait with it.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_geometric_remap_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // APB config port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fgr_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [fgr_pkg::PDATA_W-1:0]   pwdata,
  output logic      [fgr_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          req_type,
  input  wire logic [fgr_pkg::COORD_W-1:0]   row,
  input  wire logic [fgr_pkg::COORD_W-1:0]   col,
  input  wire logic [7:0]                    red_in,
  input  wire logic [7:0]                    green_in,
  input  wire logic [7:0]                    blue_in,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         red_out,
  output logic [7:0]                         green_out,
  output logic [7:0]                         blue_out,
  output logic [fgr_pkg::COORD_W-1:0]        out_row,
  output logic [fgr_pkg::COORD_W-1:0]        out_col
);

  import fgr_pkg::*;

  logic [MODE_W-1:0] remap_mode;
  logic              reg_sel;     // paddr hits the mode register
  logic              q_full;
  logic              push;
  req_entry_t        push_entry;
  logic              pop;
  logic              head_valid;
  req_entry_t        head;

  // --- configuration --------------------------------------------------------
  // word index is paddr[2]; low two bits are byte offset and ignored
  assign reg_sel = (paddr[PADDR_W-1] == REG_REMAP_MODE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      remap_mode <= MODE_IDENT;
    end else if (psel && penable && pwrite && reg_sel) begin
      remap_mode <= pwdata[MODE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[MODE_W-1:0] = remap_mode;
    end
  end

  // --- front: accept and map ------------------------------------------------
  fgr_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .row        (row),
    .col        (col),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .remap_mode (remap_mode),
    .q_full     (q_full),
    .push       (push),
    .entry      (push_entry)
  );

  // --- decoupling queue -----------------------------------------------------
  fgr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // --- back: store access and result register -------------------------------
  fgr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .out_row    (out_row),
    .out_col    (out_col)
  );

endmodule

`default_nettype wire
